// ===== sv/mma_pkg.sv =====
// Shared types, field widths, sequencer states and reciprocal table for the moving average block.
package mma_pkg;

  localparam int CHAN_W      = 3;
  localparam int SAMPLE_W    = 16;
  localparam int AVG_W       = 16;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam int DIV_W       = 5;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                command;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_out;
    logic [AVG_W-1:0]  average;
  } out_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_DIV
  } state_t;

  // floor(2^RECIP_SHIFT / d) for d = 1..16
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      5'd1:    r = 21'd1048576;
      5'd2:    r = 21'd524288;
      5'd3:    r = 21'd349525;
      5'd4:    r = 21'd262144;
      5'd5:    r = 21'd209715;
      5'd6:    r = 21'd174762;
      5'd7:    r = 21'd149796;
      5'd8:    r = 21'd131072;
      5'd9:    r = 21'd116508;
      5'd10:   r = 21'd104857;
      5'd11:   r = 21'd95325;
      5'd12:   r = 21'd87381;
      5'd13:   r = 21'd80659;
      5'd14:   r = 21'd74898;
      5'd15:   r = 21'd69905;
      5'd16:   r = 21'd65536;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/multichannel_moving_average_top.sv =====
// Multichannel moving average: top level tying sequencer, sample ring RAM and divider.
//
// Each add request writes its sample into the channel's ring of the last WINDOW samples and
// returns the truncated mean of the stored samples; a clear request empties the channel's
// history and returns nothing, and a request for a channel at or above CHANNELS is dropped.
// An add request occupies the input while it writes the ring, reads back each stored sample
// through the single read port of the ring RAM, finishes the sum and hands it to the divider.
// The handoff to the divider waits only while an earlier result sits stalled at the output.
// Clear and dropped requests do not occupy the sequencer. The divider registers the product,
// then the quotient and back-product, then the result, overlapping the next request.
// The ring needs no clearing pass after reset.
module multichannel_moving_average_top #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mma_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output mma_pkg::out_rsp_t out_rsp
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = mma_pkg::SAMPLE_W + $clog2(WINDOW);

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [mma_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [mma_pkg::SAMPLE_W-1:0] ram_rdata;
  logic                         div_valid;
  logic                         div_ready;
  logic [mma_pkg::CHAN_W-1:0]   div_channel;
  logic [SUM_W-1:0]             div_sum;
  logic [CNT_W-1:0]             div_cnt;

  mma_ctrl #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W),
    .SUM_W    (SUM_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .div_valid   (div_valid),
    .div_ready   (div_ready),
    .div_channel (div_channel),
    .div_sum     (div_sum),
    .div_cnt     (div_cnt)
  );

  mma_ram #(
    .WIDTH  (mma_pkg::SAMPLE_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mma_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (div_valid),
    .req_ready   (div_ready),
    .req_channel (div_channel),
    .req_sum     (div_sum),
    .req_cnt     (div_cnt),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp)
  );

endmodule

// ===== sv/mma_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mma_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 40,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mma_ctrl.sv =====
// Request sequencer: per-channel pointers and counts, ring write, ring read-back and summing.
module mma_ctrl #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 5,
  parameter int ADDR_W   = 6,
  parameter int CNT_W    = 3,
  parameter int SUM_W    = 19
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mma_pkg::in_req_t               in_req,
  output logic                           ram_we,
  output logic [ADDR_W-1:0]              ram_waddr,
  output logic [mma_pkg::SAMPLE_W-1:0]   ram_wdata,
  output logic [ADDR_W-1:0]              ram_raddr,
  input  logic [mma_pkg::SAMPLE_W-1:0]   ram_rdata,
  output logic                           div_valid,
  input  logic                           div_ready,
  output logic [mma_pkg::CHAN_W-1:0]     div_channel,
  output logic [SUM_W-1:0]               div_sum,
  output logic [CNT_W-1:0]               div_cnt
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LIM_W = mma_pkg::CHAN_W + 4;
  localparam logic [LIM_W-1:0] CH_LIM = LIM_W'(CHANNELS);

  mma_pkg::state_t state_r, state_nxt;

  logic [PTR_W-1:0] wp_r   [CHANNELS];
  logic [CNT_W-1:0] fill_r [CHANNELS];

  logic [ADDR_W-1:0]              base_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [CNT_W-1:0]               rd_idx_r;
  logic                           rd_pend_r;
  logic [SUM_W-1:0]               sum_r;
  logic [mma_pkg::CHAN_W-1:0]     chan_r;

  logic [CH_W-1:0]   ch_idx;
  logic              in_range;
  logic [PTR_W-1:0]  wp_cur;
  logic [PTR_W-1:0]  wp_inc;
  logic [CNT_W-1:0]  fill_cur;
  logic [CNT_W-1:0]  fill_inc;
  logic [ADDR_W-1:0] base;
  logic              accept;
  logic              add_go;
  logic              clr_go;

  assign ch_idx   = CH_W'(in_req.channel);
  assign in_range = {4'b0, in_req.channel} < CH_LIM;
  assign wp_cur   = wp_r[ch_idx];
  assign fill_cur = fill_r[ch_idx];
  assign wp_inc   = (wp_cur == PTR_W'(WINDOW - 1)) ? '0 : wp_cur + PTR_W'(1);
  assign fill_inc = (fill_cur == CNT_W'(WINDOW)) ? fill_cur : fill_cur + CNT_W'(1);
  assign base     = ADDR_W'(ch_idx * WINDOW);
  assign accept   = in_valid && in_ready;
  assign add_go   = accept && in_range && (in_req.command == mma_pkg::CMD_ADD);
  assign clr_go   = accept && in_range && (in_req.command == mma_pkg::CMD_CLEAR);

  assign ram_waddr   = base + ADDR_W'(wp_cur);
  assign ram_wdata   = in_req.sample;
  assign ram_raddr   = base_r + ADDR_W'(rd_idx_r);
  assign div_channel = chan_r;
  assign div_sum     = sum_r;
  assign div_cnt     = cnt_r;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    div_valid = 1'b0;
    case (state_r)
      mma_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (add_go) begin
          ram_we    = 1'b1;
          state_nxt = mma_pkg::S_READ;
        end
      end
      mma_pkg::S_READ: begin
        if (rd_idx_r == cnt_r - CNT_W'(1)) begin
          state_nxt = mma_pkg::S_SUM;
        end
      end
      mma_pkg::S_SUM: begin
        state_nxt = mma_pkg::S_DIV;
      end
      mma_pkg::S_DIV: begin
        div_valid = 1'b1;
        if (div_ready) begin
          state_nxt = mma_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mma_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mma_pkg::S_IDLE;
      rd_pend_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == mma_pkg::S_READ);
      if (add_go) begin
        wp_r[ch_idx]   <= wp_inc;
        fill_r[ch_idx] <= fill_inc;
      end else if (clr_go) begin
        wp_r[ch_idx]   <= '0;
        fill_r[ch_idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_go) begin
      base_r   <= base;
      cnt_r    <= fill_inc;
      chan_r   <= in_req.channel;
      rd_idx_r <= '0;
      sum_r    <= '0;
    end else begin
      if (state_r == mma_pkg::S_READ) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'(ram_rdata);
      end
    end
  end

endmodule

// ===== sv/mma_div.sv =====
// Sum-by-count divider: reciprocal multiply, back-multiply, one-step correction, result register.
module mma_div #(
  parameter int SUM_W = 19,
  parameter int CNT_W = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [mma_pkg::CHAN_W-1:0] req_channel,
  input  logic [SUM_W-1:0]           req_sum,
  input  logic [CNT_W-1:0]           req_cnt,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mma_pkg::out_rsp_t          out_rsp
);

  localparam int PROD_W = SUM_W + mma_pkg::RECIP_W;
  localparam int QD_W   = mma_pkg::AVG_W + CNT_W;

  logic s1_vld_r, s2_vld_r, out_valid_r;

  logic [PROD_W-1:0]              prod_r;
  logic [SUM_W-1:0]               sum1_r, sum2_r;
  logic [CNT_W-1:0]               cnt1_r, cnt2_r;
  logic [mma_pkg::CHAN_W-1:0]     ch1_r, ch2_r;
  logic [mma_pkg::AVG_W-1:0]      q2_r;
  logic [QD_W-1:0]                qd2_r;
  mma_pkg::out_rsp_t              out_rsp_r;

  logic                           fire;
  logic [mma_pkg::RECIP_W-1:0]    recip_v;
  logic [mma_pkg::AVG_W-1:0]      q1;
  logic [SUM_W-1:0]               rem;
  logic [mma_pkg::AVG_W-1:0]      avg;

  assign req_ready = !s1_vld_r && !s2_vld_r && (!out_valid_r || out_ready);
  assign fire      = req_valid && req_ready;
  assign recip_v   = mma_pkg::recip(mma_pkg::DIV_W'(req_cnt));
  assign q1        = prod_r[mma_pkg::RECIP_SHIFT +: mma_pkg::AVG_W];
  assign rem       = sum2_r - SUM_W'(qd2_r);
  assign avg       = (rem >= SUM_W'(cnt2_r)) ? q2_r + mma_pkg::AVG_W'(1) : q2_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r <= fire;
      s2_vld_r <= s1_vld_r;
      if (s2_vld_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prod_r <= PROD_W'(req_sum) * PROD_W'(recip_v);
      sum1_r <= req_sum;
      cnt1_r <= req_cnt;
      ch1_r  <= req_channel;
    end
    if (s1_vld_r) begin
      q2_r   <= q1;
      qd2_r  <= QD_W'(q1) * QD_W'(cnt1_r);
      sum2_r <= sum1_r;
      cnt2_r <= cnt1_r;
      ch2_r  <= ch1_r;
    end
    if (s2_vld_r) begin
      out_rsp_r.channel_out <= ch2_r;
      out_rsp_r.average     <= avg;
    end
  end

endmodule

// ===== sv/mma_checker.sv =====
// Port-level checker for the moving average block and its bind to the top level.
module mma_checker #(
  parameter int CHANNELS = 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input mma_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_ready,
  input mma_pkg::out_rsp_t out_rsp
);

  localparam int LIM_W = mma_pkg::CHAN_W + 4;
  localparam logic [LIM_W-1:0] CH_LIM = LIM_W'(CHANNELS);

  logic in_chan_ok;
  logic out_chan_ok;

  assign in_chan_ok  = {4'b0, in_req.channel} < CH_LIM;
  assign out_chan_ok = {4'b0, out_rsp.channel_out} < CH_LIM;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed or dropped");

  a_out_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chan_ok)
    else $error("result for a channel that does not exist");

  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_chan_ok && (in_req.command == mma_pkg::CMD_ADD) |=> !in_ready)
    else $error("add request did not occupy the sequencer");

  a_short_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!in_chan_ok || (in_req.command == mma_pkg::CMD_CLEAR))
    |=> in_ready)
    else $error("clear or dropped request held the sequencer");

endmodule

bind multichannel_moving_average_top mma_checker #(.CHANNELS(CHANNELS)) u_mma_checker (.*);
